@@ design/slpd_pkg.sv @@
`timescale 1ns / 1ps

package slpd_pkg;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_FIRST_SYNC  = 2'd0;
  localparam logic [1:0] REG_SECOND_SYNC = 2'd1;
  localparam logic [1:0] REG_MAX_LEN     = 2'd2;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  // Reset values of the configuration registers
  localparam logic [7:0]  FIRST_SYNC_RST  = 8'hAA;
  localparam logic [7:0]  SECOND_SYNC_RST = 8'h55;
  localparam logic [15:0] MAX_LEN_RST     = 16'd248;

  // CRC8 generator polynomial x^8 + x^2 + x + 1
  localparam logic [7:0] CRC_POLY = 8'h07;

  // Result event codes
  localparam logic [1:0] EV_PARAM  = 2'd0;
  localparam logic [1:0] EV_ACCEPT = 2'd1;
  localparam logic [1:0] EV_REJECT = 2'd2;

  typedef enum logic [2:0] {
    PH_SYNC1  = 3'd0,
    PH_SYNC2  = 3'd1,
    PH_CMD    = 3'd2,
    PH_LENHI  = 3'd3,
    PH_LENLO  = 3'd4,
    PH_PARAMS = 3'd5,
    PH_CHECK  = 3'd6
  } phase_t;

  typedef struct packed {
    logic [7:0]  first_sync;
    logic [7:0]  second_sync;
    logic [15:0] max_len;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [7:0]  command;
    logic [7:0]  param_byte;
    logic [15:0] param_index;
    logic [15:0] param_length;
  } result_t;

  // One byte through CRC8, MSB first, no reflection
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ design/slpd_cfg_regs.sv @@
`timescale 1ns / 1ps

module slpd_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [slpd_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [slpd_pkg::CfgDataW-1:0]   cfg_wdata,
  output slpd_pkg::cfg_t                  cfg
);
  import slpd_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the write; an index beyond the list is dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_FIRST_SYNC:  cfg_nxt.first_sync  = cfg_wdata[7:0];
        REG_SECOND_SYNC: cfg_nxt.second_sync = cfg_wdata[7:0];
        REG_MAX_LEN:     cfg_nxt.max_len     = cfg_wdata;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.first_sync  <= FIRST_SYNC_RST;
      cfg_r.second_sync <= SECOND_SYNC_RST;
      cfg_r.max_len     <= MAX_LEN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ design/slpd_parser.sv @@
`timescale 1ns / 1ps

module slpd_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  slpd_pkg::cfg_t    cfg,
  input  logic              step,
  input  logic [7:0]        byte_in,
  output logic              res_valid,
  output slpd_pkg::result_t res
);
  import slpd_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  command_r, command_nxt;
  logic [15:0] declared_length_r, declared_length_nxt;
  logic [15:0] bytes_received_r, bytes_received_nxt;
  logic [7:0]  header_crc_r, header_crc_nxt;
  logic [7:0]  payload_crc_r, payload_crc_nxt;

  logic [16:0] cnt_inc;
  logic [15:0] len_full;
  logic [7:0]  crc_in;
  logic [7:0]  crc_out;

  // One shared CRC step, fed from whichever running value the phase needs, or zero for the command byte
  assign crc_in  = (phase_r == PH_PARAMS) ? payload_crc_r :
                   (phase_r == PH_CMD)    ? 8'h00 : header_crc_r;
  assign crc_out = crc8_update(crc_in, byte_in);

  assign cnt_inc  = {1'b0, bytes_received_r} + 17'd1;
  assign len_full = {declared_length_r[15:8], byte_in};

  // Next phase and the result that this beat causes
  always_comb begin
    phase_nxt           = phase_r;
    command_nxt         = command_r;
    declared_length_nxt = declared_length_r;
    bytes_received_nxt  = bytes_received_r;
    header_crc_nxt      = header_crc_r;
    payload_crc_nxt     = payload_crc_r;
    res_valid           = 1'b0;
    res.event_res       = EV_PARAM;
    res.command         = command_r;
    res.param_byte      = 8'h00;
    res.param_index     = 16'h0000;
    res.param_length    = declared_length_r;

    unique case (phase_r)
      PH_SYNC1: begin
        if (byte_in == cfg.first_sync) begin
          phase_nxt = PH_SYNC2;
        end
      end
      PH_SYNC2: begin
        phase_nxt = (byte_in == cfg.second_sync) ? PH_CMD : PH_SYNC1;
      end
      PH_CMD: begin
        command_nxt    = byte_in;
        header_crc_nxt = crc_out;
        phase_nxt      = PH_LENHI;
      end
      PH_LENHI: begin
        declared_length_nxt = {byte_in, 8'h00};
        header_crc_nxt      = crc_out;
        phase_nxt           = PH_LENLO;
      end
      PH_LENLO: begin
        declared_length_nxt = len_full;
        header_crc_nxt      = crc_out;
        payload_crc_nxt     = 8'h00;
        bytes_received_nxt  = 16'h0000;
        priority if (len_full > cfg.max_len) begin
          phase_nxt = PH_SYNC1;
        end else if (len_full == 16'h0000) begin
          phase_nxt = PH_CHECK;
        end else begin
          phase_nxt = PH_PARAMS;
        end
      end
      PH_PARAMS: begin
        res_valid          = 1'b1;
        res.event_res      = EV_PARAM;
        res.param_byte     = byte_in;
        res.param_index    = bytes_received_r;
        payload_crc_nxt    = crc_out;
        bytes_received_nxt = cnt_inc[15:0];
        if (cnt_inc >= {1'b0, declared_length_r}) begin
          phase_nxt = PH_CHECK;
        end
      end
      PH_CHECK: begin
        res_valid     = 1'b1;
        res.event_res = (byte_in == (header_crc_r ^ payload_crc_r)) ? EV_ACCEPT : EV_REJECT;
        phase_nxt     = PH_SYNC1;
      end
      default: begin
        phase_nxt = PH_SYNC1;
      end
    endcase
  end

  // Advance the frame state on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r           <= PH_SYNC1;
      command_r         <= 8'h00;
      declared_length_r <= 16'h0000;
      bytes_received_r  <= 16'h0000;
      header_crc_r      <= 8'h00;
      payload_crc_r     <= 8'h00;
    end else if (step) begin
      phase_r           <= phase_nxt;
      command_r         <= command_nxt;
      declared_length_r <= declared_length_nxt;
      bytes_received_r  <= bytes_received_nxt;
      header_crc_r      <= header_crc_nxt;
      payload_crc_r     <= payload_crc_nxt;
    end
  end

`ifndef SYNTHESIS
  a_check_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    step && phase_r == PH_CHECK |=> phase_r == PH_SYNC1)
    else $error("parser did not return to hunting after the check byte");

  a_count_advances: assert property (@(posedge clk) disable iff (!rst_n)
    step && phase_r == PH_PARAMS |=> bytes_received_r == $past(bytes_received_r) + 16'd1)
    else $error("parameter count did not advance");

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PARAMS |-> bytes_received_r < declared_length_r)
    else $error("parameter count ran past the declared length");

  a_result_phase: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (phase_r == PH_PARAMS || phase_r == PH_CHECK))
    else $error("result raised outside parameter or check phase");
`endif

endmodule

@@ design/slpd_out_stage.sv @@
`timescale 1ns / 1ps

module slpd_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  slpd_pkg::result_t res,
  output logic              can_load,
  output logic              out_valid,
  input  logic              out_ready,
  output slpd_pkg::result_t out_res
);
  import slpd_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r;

  // Free when empty or when the held result leaves this cycle
  assign can_load = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Hold the payload until a new result replaces it
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

@@ design/sync_length_crc8_packet_deframer_top.sv @@
`timescale 1ns / 1ps

// Sync-word, length-prefixed frame deframer with CRC8 check.
// Input channel (in_valid/in_ready/in_byte_in) takes one stream byte per beat.
// Frames are sync1, sync2, command, length hi, length lo, parameters, CRC8.
// Result channel (out_valid/out_ready/out_*) gives one beat per parameter byte
// (event 0, with its index), and one beat per check byte: event 1 when the
// CRC matches, event 2 when it does not. Oversized frames emit nothing.
// Configuration port (cfg_we/cfg_index/cfg_wdata) sets the two sync bytes
// and the largest parameter length; write it only while the block is idle.
// A result is registered and appears in the cycle after its byte is taken. One
// byte per cycle is taken while the output register can take its result; the
// frame state and one CRC8 byte step sit between the input handshake and the
// single output register. The output register frees itself on the beat it is
// taken, so in_ready stays high while out_ready is high. When the receiver
// stalls with a result held, in_ready drops until that result is taken.
// Reset (rst_n low, synchronous) restores the sync bytes 0xAA and 0x55,
// a length limit of 248, empties the output and hunts for sync1.

module sync_length_crc8_packet_deframer_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_byte_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_event_res,
  output logic [7:0]                    out_command,
  output logic [7:0]                    out_param_byte,
  output logic [15:0]                   out_param_index,
  output logic [15:0]                   out_param_length,
  input  logic                          cfg_we,
  input  logic [slpd_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [slpd_pkg::CfgDataW-1:0] cfg_wdata
);
  import slpd_pkg::*;

  cfg_t    cfg;
  result_t res;
  result_t out_res;
  logic    res_valid;
  logic    can_load;
  logic    step;

  // Accept a byte whenever the output register can take its result
  assign in_ready = can_load;
  assign step     = in_valid && can_load;

  slpd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  slpd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .step      (step),
    .byte_in   (in_byte_in),
    .res_valid (res_valid),
    .res       (res)
  );

  slpd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step && res_valid),
    .res       (res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_event_res    = out_res.event_res;
  assign out_command      = out_res.command;
  assign out_param_byte   = out_res.param_byte;
  assign out_param_index  = out_res.param_index;
  assign out_param_length = out_res.param_length;

endmodule

@@ dv/frame_event_checker.sv @@
`timescale 1ns / 1ps

module frame_event_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [7:0]                    in_byte_in,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [1:0]                    out_event_res,
  input  logic [7:0]                    out_command,
  input  logic [7:0]                    out_param_byte,
  input  logic [15:0]                   out_param_index,
  input  logic [15:0]                   out_param_length,
  input  logic                          cfg_we,
  input  logic [slpd_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [slpd_pkg::CfgDataW-1:0] cfg_wdata,
  output int                            errors,
  output int                            pending
);

  import slpd_pkg::*;

  // Shadow of the configuration registers and of the frame parser
  cfg_t        cfg_now;
  phase_t      phase;
  logic [7:0]  frame_cmd;
  logic [15:0] frame_len;
  logic [15:0] param_count;
  logic [7:0]  hdr_crc;
  logic [7:0]  pay_crc;

  // Frame events still owed by the block, oldest first
  result_t     owed_events[$];

  // CRC8, polynomial x^8 + x^2 + x + 1, MSB first, zero start
  function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    int         k;
    c = crc ^ b;
    for (k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ 8'h07) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  // Advance the parser by one stream byte; queue the event it raises
  task automatic parse_byte(input logic [7:0] b);
    result_t     ev;
    logic [7:0]  want_crc;
    logic [16:0] next_count;
    case (phase)
      PH_SYNC1: begin
        if (b == cfg_now.first_sync) phase = PH_SYNC2;
      end
      PH_SYNC2: begin
        // a wrong second sync is not retried as a first sync
        phase = (b == cfg_now.second_sync) ? PH_CMD : PH_SYNC1;
      end
      PH_CMD: begin
        frame_cmd = b;
        hdr_crc   = crc_byte(8'h00, b);
        phase     = PH_LENHI;
      end
      PH_LENHI: begin
        frame_len = {b, 8'h00};
        hdr_crc   = crc_byte(hdr_crc, b);
        phase     = PH_LENLO;
      end
      PH_LENLO: begin
        frame_len[7:0] = b;
        hdr_crc        = crc_byte(hdr_crc, b);
        pay_crc        = 8'h00;
        param_count    = 16'd0;
        if (frame_len > cfg_now.max_len) begin
          phase = PH_SYNC1;
        end else if (frame_len == 16'd0) begin
          phase = PH_CHECK;
        end else begin
          phase = PH_PARAMS;
        end
      end
      PH_PARAMS: begin
        ev.event_res    = EV_PARAM;
        ev.command      = frame_cmd;
        ev.param_byte   = b;
        ev.param_index  = param_count;
        ev.param_length = frame_len;
        owed_events.push_back(ev);
        pay_crc     = crc_byte(pay_crc, b);
        next_count  = {1'b0, param_count} + 17'd1;
        param_count = next_count[15:0];
        if (next_count >= {1'b0, frame_len}) phase = PH_CHECK;
      end
      PH_CHECK: begin
        want_crc        = hdr_crc ^ pay_crc;
        ev.event_res    = (b == want_crc) ? EV_ACCEPT : EV_REJECT;
        ev.command      = frame_cmd;
        ev.param_byte   = 8'h00;
        ev.param_index  = 16'd0;
        ev.param_length = frame_len;
        owed_events.push_back(ev);
        phase = PH_SYNC1;
      end
      default: begin
        phase = PH_SYNC1;
      end
    endcase
  endtask

  // Compare one result beat against the oldest owed event
  task automatic compare_beat();
    result_t want;
    result_t got;
    got = {out_event_res, out_command, out_param_byte, out_param_index, out_param_length};
    if (owed_events.size() == 0) begin
      errors++;
      $display("%0t: extra beat: expected none, got ev %0d cmd %h byte %h idx %0d len %0d",
               $time, got.event_res, got.command, got.param_byte, got.param_index,
               got.param_length);
    end else begin
      want = owed_events.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: result beat differs: expected ev %0d cmd %02h byte %02h idx %0d len %0d",
                 $time, want.event_res, want.command, want.param_byte, want.param_index,
                 want.param_length);
        $display("%0t:                      actual   ev %0d cmd %02h byte %02h idx %0d len %0d",
                 $time, got.event_res, got.command, got.param_byte, got.param_index,
                 got.param_length);
      end
    end
  endtask

  // Watch the three ports at each rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_now.first_sync  = FIRST_SYNC_RST;
      cfg_now.second_sync = SECOND_SYNC_RST;
      cfg_now.max_len     = MAX_LEN_RST;
      phase       = PH_SYNC1;
      frame_cmd   = 8'h00;
      frame_len   = 16'd0;
      param_count = 16'd0;
      hdr_crc     = 8'h00;
      pay_crc     = 8'h00;
      owed_events.delete();
      errors      = 0;
      pending     <= 0;
    end else begin
      if (out_valid && out_ready) compare_beat();
      // a byte taken on a write edge still sees the old register value
      if (in_valid && in_ready) parse_byte(in_byte_in);
      if (cfg_we) begin
        case (cfg_index)
          REG_FIRST_SYNC:  cfg_now.first_sync  = cfg_wdata[7:0];
          REG_SECOND_SYNC: cfg_now.second_sync = cfg_wdata[7:0];
          REG_MAX_LEN:     cfg_now.max_len     = cfg_wdata[15:0];
          default: ;
        endcase
      end
      pending <= owed_events.size();
    end
  end

endmodule

@@ dv/tb_sync_length_crc8_packet_deframer_top.sv @@
`timescale 1ns / 1ps

module tb_sync_length_crc8_packet_deframer_top;

  import slpd_pkg::*;

  localparam int                   CYCLE_LIMIT  = 200000;
  localparam logic [CfgIdxW-1:0]   REG_UNMAPPED = 2'd3;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [7:0]          in_byte_in;
  logic                out_valid;
  logic                out_ready;
  logic [1:0]          out_event_res;
  logic [7:0]          out_command;
  logic [7:0]          out_param_byte;
  logic [15:0]         out_param_index;
  logic [15:0]         out_param_length;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_wdata;

  int errors;
  int pending;
  int snd_idle;
  int rcv_idle;
  int bytes_sent;
  int cycles;

  // Register values the stream generator builds frames for
  logic [7:0]  sync1_v;
  logic [7:0]  sync2_v;
  logic [15:0] maxlen_v;

  sync_length_crc8_packet_deframer_top uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte_in       (in_byte_in),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_event_res    (out_event_res),
    .out_command      (out_command),
    .out_param_byte   (out_param_byte),
    .out_param_index  (out_param_index),
    .out_param_length (out_param_length),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  frame_event_checker event_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte_in       (in_byte_in),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_event_res    (out_event_res),
    .out_command      (out_command),
    .out_param_byte   (out_param_byte),
    .out_param_index  (out_param_index),
    .out_param_length (out_param_length),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .errors           (errors),
    .pending          (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Stall the result channel at random
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready = ($urandom_range(0, 99) >= rcv_idle);
    end
  end

  // Give up on a hung run
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("sync_length_crc8_packet_deframer_top: mismatch");
    $finish;
  end

  // Check byte generator for well-formed frames
  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    int         k;
    c = crc ^ b;
    for (k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ 8'h07;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  // Offer one byte, idling first at random; return once it is taken
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(0, 99) < snd_idle) begin
      in_valid   = 1'b0;
      in_byte_in = 8'($urandom);
      @(negedge clk);
    end
    in_valid   = 1'b1;
    in_byte_in = b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Hold the input off until every owed event has come out
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic set_regs(input logic [7:0] s1, input logic [7:0] s2, input logic [15:0] ml);
    sync1_v  = s1;
    sync2_v  = s2;
    maxlen_v = ml;
    write_reg(REG_FIRST_SYNC, {8'h00, s1});
    write_reg(REG_SECOND_SYNC, {8'h00, s2});
    write_reg(REG_MAX_LEN, ml);
  endtask

  // Header, n_params random parameters, then optionally the check byte
  task automatic send_frame(input logic [7:0] cmd, input logic [15:0] len, input bit good,
                            input int n_params, input bit with_check);
    logic [7:0] hcrc;
    logic [7:0] pcrc;
    logic [7:0] pb;
    logic [7:0] chk;
    int         i;
    hcrc = crc8_next(8'h00, cmd);
    hcrc = crc8_next(hcrc, len[15:8]);
    hcrc = crc8_next(hcrc, len[7:0]);
    pcrc = 8'h00;
    send_byte(sync1_v);
    send_byte(sync2_v);
    send_byte(cmd);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
    for (i = 0; i < n_params; i++) begin
      pb   = 8'($urandom);
      pcrc = crc8_next(pcrc, pb);
      send_byte(pb);
    end
    if (with_check) begin
      chk = hcrc ^ pcrc;
      if (!good) chk = chk ^ (8'h01 << $urandom_range(0, 7));
      send_byte(chk);
    end
  endtask

  // Mostly short lengths, some at the limit, some just or far beyond it
  function automatic logic [15:0] pick_len();
    int r;
    int lim;
    r   = $urandom_range(0, 99);
    lim = (maxlen_v < 16'd10) ? int'(maxlen_v) : 10;
    if (r < 70) return 16'($urandom_range(0, lim));
    if (r < 85 && maxlen_v <= 16'd40) return maxlen_v;
    if (maxlen_v != 16'hFFFF) begin
      if (r < 92) return maxlen_v + 16'd1;
      return 16'($urandom_range(int'(maxlen_v) + 1, 65535));
    end
    return 16'($urandom_range(0, lim));
  endfunction

  // One piece of random stream: a frame, noise, a broken sync or a cut frame
  task automatic random_piece();
    int          kind;
    int          n;
    int          i;
    logic [15:0] len;
    logic [7:0]  b;
    kind = $urandom_range(0, 99);
    if (kind < 78) begin
      len = pick_len();
      if (len > maxlen_v) begin
        send_frame(8'($urandom), len, 1'b1, 0, 1'b0);
      end else begin
        send_frame(8'($urandom), len, $urandom_range(0, 99) < 75, int'(len), 1'b1);
      end
    end else if (kind < 86) begin
      n = $urandom_range(1, 6);
      for (i = 0; i < n; i++) send_byte(8'($urandom));
    end else if (kind < 93) begin
      b = 8'($urandom);
      if (b == sync2_v) b = ~b;
      send_byte(sync1_v);
      send_byte(b);
    end else if (maxlen_v >= 16'd2) begin
      len = 16'($urandom_range(2, (maxlen_v < 16'd10) ? int'(maxlen_v) : 10));
      send_frame(8'($urandom), len, 1'b1, $urandom_range(0, int'(len) - 1), 1'b0);
    end else begin
      send_byte(8'($urandom));
    end
    if ($urandom_range(0, 99) < 4) drain_results();
  endtask

  initial begin
    int phase_no;
    int target;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_byte_in = 8'h00;
    cfg_we     = 1'b0;
    cfg_index  = REG_FIRST_SYNC;
    cfg_wdata  = '0;
    snd_idle   = 21;
    rcv_idle   = 50;
    bytes_sent = 0;
    sync1_v    = FIRST_SYNC_RST;
    sync2_v    = SECOND_SYNC_RST;
    maxlen_v   = MAX_LEN_RST;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: zero length, extreme command, wrong second sync,
    // oversized length, check byte mismatch
    send_frame(8'h00, 16'd0, 1'b1, 0, 1'b1);
    send_frame(8'hFF, 16'd2, 1'b1, 2, 1'b1);
    send_byte(sync1_v);
    send_byte(sync1_v);
    send_byte(sync2_v);
    send_frame(8'h5A, 16'hFFFF, 1'b1, 0, 1'b0);
    send_frame(8'h7E, 16'd1, 1'b0, 1, 1'b1);

    // Random phases, each under its own register setting
    for (phase_no = 0; phase_no < 4; phase_no++) begin
      drain_results();
      case (phase_no)
        0: begin
          write_reg(REG_UNMAPPED, 16'hFFFF);
          set_regs(8'h00, 8'hFF, 16'hFFFF);
          snd_idle = 21;
          rcv_idle = 50;
        end
        1: begin
          set_regs(8'hFF, 8'h00, 16'd0);
          snd_idle = 50;
          rcv_idle = 21;
        end
        2: begin
          set_regs(8'h3C, 8'h3C, 16'd12);
          snd_idle = 0;
          rcv_idle = 0;
        end
        default: begin
          set_regs(8'hAA, 8'h55, 16'hFFFE);
          snd_idle = 0;
          rcv_idle = 0;
        end
      endcase
      target = bytes_sent + ((phase_no == 0) ? 300 : 110);
      // one long frame carries the parameter index past a byte
      if (phase_no == 0) send_frame(8'($urandom), 16'd260, 1'b1, 260, 1'b1);
      while (bytes_sent < target) random_piece();
    end

    drain_results();
    repeat (8) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("sync_length_crc8_packet_deframer_top: match");
    end else begin
      $display("sync_length_crc8_packet_deframer_top: mismatch");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/slpd_pkg.sv
design/slpd_cfg_regs.sv
design/slpd_parser.sv
design/slpd_out_stage.sv
design/sync_length_crc8_packet_deframer_top.sv
dv/frame_event_checker.sv
dv/tb_sync_length_crc8_packet_deframer_top.sv
